### sv/record_header_checker_unit_assert.svh
// Assertion macros for the record header checker.
// Used by the top level; relies on clk and rst_n being in scope.
`ifndef RECORD_HEADER_CHECKER_UNIT_ASSERT_SVH
`define RECORD_HEADER_CHECKER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RHC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RHC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/rhc_pkg.sv
// Shared types, constants and the CRC-32 byte update of the record header checker.
// No dependencies; used by rhc_parser and record_header_checker_unit.
`default_nettype none

package rhc_pkg;

    localparam int HEADER_BYTES_DEF = 40;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [31:0] CRC_ALL_ONES       = 32'hffff_ffff;
    localparam logic [31:0] CRC_POLY_REFLECTED = 32'hedb8_8320;

    localparam logic [31:0] MAGIC_WORD_RST      = 32'd0;
    localparam logic [15:0] FORMAT_VERSION_RST  = 16'd1;
    localparam logic [31:0] SAMPLE_TARGET_RST   = 32'd16000;
    localparam logic [31:0] PAYLOAD_TARGET_RST  = 32'd0;
    localparam logic [31:0] SLOT_SIZE_RST       = 32'd8192;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MAGIC_WORD     = 3'd0,
        CFG_FORMAT_VERSION = 3'd1,
        CFG_SAMPLE_TARGET  = 3'd2,
        CFG_PAYLOAD_TARGET = 3'd3,
        CFG_SLOT_SIZE      = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        STATUS_VALID        = 2'd0,
        STATUS_BAD_IDENTITY = 2'd1,
        STATUS_CRC_MISMATCH = 2'd2,
        STATUS_BAD_LENGTH   = 2'd3
    } status_t;

    typedef struct packed {
        logic [31:0] magic_word;
        logic [15:0] format_version;
        logic [31:0] sample_target;
        logic [31:0] payload_target;
        logic [31:0] slot_size;
    } cfg_t;

    typedef struct packed {
        logic       first;
        logic [7:0] header_byte;
    } step_t;

    // The first member sits in the highest bits, so status ends up lowest.
    typedef struct packed {
        logic [31:0]        header_crc;
        logic [31:0]        payload_crc;
        logic [31:0]        payload_length;
        logic [31:0]        sample_total;
        logic signed [63:0] start_time;
        logic [63:0]        sequence_res;
        status_t            status;
    } result_t;

    localparam int RESULT_W    = $bits(result_t);
    localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - RESULT_W;

    // One byte of the reflected CRC-32, eight shift steps unrolled.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
        logic [31:0] c;
        c = crc ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY_REFLECTED) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### sv/rhc_parser.sv
// Header parser: byte position, running CRC, identity checks and field capture.
// Depends on rhc_pkg; instantiated by record_header_checker_unit.
`default_nettype none

module rhc_parser #(
    parameter int HEADER_BYTES = rhc_pkg::HEADER_BYTES_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step_en,
    input  wire rhc_pkg::step_t   step,
    input  wire rhc_pkg::cfg_t    cfg,
    output logic                  step_last,
    output rhc_pkg::result_t      step_result
);

    localparam int POS_W = $clog2(HEADER_BYTES + 1);

    localparam logic [POS_W-1:0] POS_MAGIC_END   = POS_W'(3);
    localparam logic [POS_W-1:0] POS_VERSION_END = POS_W'(5);
    localparam logic [POS_W-1:0] POS_HSIZE_END   = POS_W'(7);
    localparam logic [POS_W-1:0] POS_SEQUENCE    = POS_W'(8);
    localparam logic [POS_W-1:0] POS_START_TIME  = POS_W'(16);
    localparam logic [POS_W-1:0] POS_COUNT       = POS_W'(24);
    localparam logic [POS_W-1:0] POS_LENGTH      = POS_W'(28);
    localparam logic [POS_W-1:0] POS_PAYLOAD_CRC = POS_W'(32);
    localparam logic [POS_W-1:0] POS_HEADER_CRC  = POS_W'(36);
    localparam logic [POS_W-1:0] POS_FIXED_END   = POS_W'(40);
    localparam logic [POS_W-1:0] POS_END         = POS_W'(HEADER_BYTES);
    localparam logic [POS_W-1:0] POS_LAST        = POS_W'(HEADER_BYTES - 1);

    logic [POS_W-1:0]   pos_reg, pos_next, pos_eff;
    logic [31:0]        crc_reg, crc_next, crc_base;
    logic               identity_ok_reg, identity_ok_next, identity_base;
    logic [31:0]        field_shift_reg, field_shift_next;
    logic [63:0]        sequence_reg, sequence_next;
    logic [63:0]        start_time_reg, start_time_next;
    logic [31:0]        count_reg, count_next;
    logic [31:0]        length_reg, length_next;
    logic [31:0]        payload_crc_reg, payload_crc_next;
    logic [31:0]        stored_crc_reg, stored_crc_next;
    logic               in_header;
    logic               length_fits;
    logic [7:0]         crc_data;

    always_comb
    begin
        // A first flag restarts the header before this byte is taken.
        pos_eff       = step.first ? '0 : pos_reg;
        crc_base      = step.first ? rhc_pkg::CRC_ALL_ONES : crc_reg;
        identity_base = step.first ? 1'b1 : identity_ok_reg;
        in_header     = (pos_eff < POS_END);
        step_last     = (pos_eff == POS_LAST);

        pos_next         = pos_eff + POS_W'(1);
        field_shift_next = {step.header_byte, field_shift_reg[31:8]};

        // The stored header CRC bytes enter the CRC as zeros.
        crc_data = (pos_eff >= POS_HEADER_CRC && pos_eff < POS_FIXED_END) ?
                   8'd0 : step.header_byte;
        crc_next = rhc_pkg::crc_byte(crc_base, crc_data);

        identity_ok_next = identity_base;
        if (pos_eff == POS_MAGIC_END && field_shift_next != cfg.magic_word)
            identity_ok_next = 1'b0;
        if (pos_eff == POS_VERSION_END && field_shift_next[31:16] != cfg.format_version)
            identity_ok_next = 1'b0;
        if (pos_eff == POS_HSIZE_END && field_shift_next[31:16] != 16'(HEADER_BYTES))
            identity_ok_next = 1'b0;

        // Every byte of a completed header is written once, so a plain overwrite
        // gives the same holds as clearing them at restart.
        sequence_next    = sequence_reg;
        start_time_next  = start_time_reg;
        count_next       = count_reg;
        length_next      = length_reg;
        payload_crc_next = payload_crc_reg;
        stored_crc_next  = stored_crc_reg;
        if (pos_eff >= POS_SEQUENCE && pos_eff < POS_START_TIME)
            sequence_next[{pos_eff[2:0], 3'b000} +: 8] = step.header_byte;
        if (pos_eff >= POS_START_TIME && pos_eff < POS_COUNT)
            start_time_next[{pos_eff[2:0], 3'b000} +: 8] = step.header_byte;
        if (pos_eff >= POS_COUNT && pos_eff < POS_LENGTH)
            count_next[{pos_eff[1:0], 3'b000} +: 8] = step.header_byte;
        if (pos_eff >= POS_LENGTH && pos_eff < POS_PAYLOAD_CRC)
            length_next[{pos_eff[1:0], 3'b000} +: 8] = step.header_byte;
        if (pos_eff >= POS_PAYLOAD_CRC && pos_eff < POS_HEADER_CRC)
            payload_crc_next[{pos_eff[1:0], 3'b000} +: 8] = step.header_byte;
        if (pos_eff >= POS_HEADER_CRC && pos_eff < POS_FIXED_END)
            stored_crc_next[{pos_eff[1:0], 3'b000} +: 8] = step.header_byte;

        length_fits = ({1'b0, length_next} + 33'(HEADER_BYTES)) <= {1'b0, cfg.slot_size};

        priority if (!identity_ok_next)
            step_result.status = rhc_pkg::STATUS_BAD_IDENTITY;
        else if ((crc_next ^ rhc_pkg::CRC_ALL_ONES) != stored_crc_next)
            step_result.status = rhc_pkg::STATUS_CRC_MISMATCH;
        else if (count_next != cfg.sample_target ||
                 length_next != cfg.payload_target || !length_fits)
            step_result.status = rhc_pkg::STATUS_BAD_LENGTH;
        else
            step_result.status = rhc_pkg::STATUS_VALID;

        step_result.sequence_res   = sequence_next;
        step_result.start_time     = start_time_next;
        step_result.sample_total   = count_next;
        step_result.payload_length = length_next;
        step_result.payload_crc    = payload_crc_next;
        step_result.header_crc     = stored_crc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            crc_reg         <= rhc_pkg::CRC_ALL_ONES;
            identity_ok_reg <= 1'b1;
        end
        else if (step_en && in_header)
        begin
            pos_reg         <= pos_next;
            crc_reg         <= crc_next;
            identity_ok_reg <= identity_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en && in_header)
        begin
            field_shift_reg <= field_shift_next;
            sequence_reg    <= sequence_next;
            start_time_reg  <= start_time_next;
            count_reg       <= count_next;
            length_reg      <= length_next;
            payload_crc_reg <= payload_crc_next;
            stored_crc_reg  <= stored_crc_next;
        end
    end

endmodule

`default_nettype wire

### sv/record_header_checker_unit.sv
// Record header checker, top level: stream ports, configuration registers,
// input and result registers. Depends on rhc_pkg, rhc_parser and the assertion header.
//
// Usage: header bytes arrive on the s_axis channel, one byte per transaction,
// in address order; tuser marks the first byte of a header and restarts parsing.
// After the last header byte one result transaction leaves on m_axis with the
// status code and the captured fields; other bytes give no result, and bytes
// past a complete header are dropped until the next first byte.
// The last byte passes through the input register, then the result register, and
// the result is presented on m_axis. Throughput: one byte per cycle, set by the
// byte-wide CRC update between the input and result registers, while the result
// slot is free for the last byte of a header.
// Configuration registers are written through cfg_we/cfg_index/cfg_data, by the user
// only while no header is in flight, unchecked by the block; unused indexes ignored.
// Reset clears the configuration to its defaults, empties both registers and
// puts the parser at byte 0. When the receiver stalls, the waiting result holds
// and one more byte is taken into the input register; bytes that give no result
// keep flowing, and the last byte of the next header waits for the result slot.
`default_nettype none

module record_header_checker_unit #(
    parameter int HEADER_BYTES = rhc_pkg::HEADER_BYTES_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // Configuration write port.
    input  wire logic                               cfg_we,
    input  wire logic [rhc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [rhc_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Header byte stream.
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [7:0]                         s_axis_tdata,  // [7:0] header_byte
    input  wire logic [0:0]                         s_axis_tuser,  // [0] first
    // Result stream.
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // From bit 0: status[1:0], sequence_res[65:2], start_time[129:66],
    // sample_total[161:130], payload_length[193:162], payload_crc[225:194],
    // header_crc[257:226], zero padding above.
    output logic [rhc_pkg::OUT_TDATA_W-1:0]         m_axis_tdata
);

    rhc_pkg::cfg_t      cfg_reg;
    logic               in_valid_reg;
    rhc_pkg::step_t     in_step_reg;
    logic               out_valid_reg;
    rhc_pkg::result_t   out_result_reg;

    logic               s_accept;
    logic               out_free;
    logic               step_last;
    logic               step_consume;
    rhc_pkg::result_t   step_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.magic_word     <= rhc_pkg::MAGIC_WORD_RST;
            cfg_reg.format_version <= rhc_pkg::FORMAT_VERSION_RST;
            cfg_reg.sample_target  <= rhc_pkg::SAMPLE_TARGET_RST;
            cfg_reg.payload_target <= rhc_pkg::PAYLOAD_TARGET_RST;
            cfg_reg.slot_size      <= rhc_pkg::SLOT_SIZE_RST;
        end
        else if (cfg_we)
        begin
            unique case (rhc_pkg::cfg_index_t'(cfg_index))
                rhc_pkg::CFG_MAGIC_WORD:     cfg_reg.magic_word <= cfg_data;
                rhc_pkg::CFG_FORMAT_VERSION: cfg_reg.format_version <= cfg_data[15:0];
                rhc_pkg::CFG_SAMPLE_TARGET:  cfg_reg.sample_target <= cfg_data;
                rhc_pkg::CFG_PAYLOAD_TARGET: cfg_reg.payload_target <= cfg_data;
                rhc_pkg::CFG_SLOT_SIZE:      cfg_reg.slot_size <= cfg_data;
                default: ;
            endcase
        end
    end

    // Only a byte that completes a header needs the result slot.
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign step_consume  = in_valid_reg && (!step_last || out_free);
    assign s_axis_tready = !in_valid_reg || step_consume;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_accept)
            in_valid_reg <= 1'b1;
        else if (step_consume)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_step_reg.first       <= s_axis_tuser[0];
            in_step_reg.header_byte <= s_axis_tdata;
        end
    end

    rhc_parser #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (step_consume),
        .step        (in_step_reg),
        .cfg         (cfg_reg),
        .step_last   (step_last),
        .step_result (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step_consume && step_last)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step_consume && step_last)
            out_result_reg <= step_result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{rhc_pkg::OUT_PAD_W{1'b0}}, out_result_reg};

`include "record_header_checker_unit_assert.svh"

    `RHC_ASSERT_NEXT(a_result_loaded, step_consume && step_last, m_axis_tvalid, "no result")
    `RHC_ASSERT_NOW(a_no_overwrite, step_consume && step_last, out_free, "result overwritten")
    `RHC_ASSERT_NEXT(a_input_held, in_valid_reg && !step_consume,
                     in_valid_reg && $stable(in_step_reg), "stalled input byte lost")

endmodule

`default_nettype wire

### dv/record_header_checker_unit_tb.sv
// Self-checking testbench for record_header_checker_unit: directed and random header byte
// streams with idle and back-pressure phases, scored against an in-bench predictor.
// Depends on rhc_pkg and the record_header_checker_unit RTL only.
`timescale 1ns / 100ps

module record_header_checker_unit_tb;

    localparam int HDR_LEN       = rhc_pkg::HEADER_BYTES_DEF;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 400000;

    // Header fields in address order: the last member lands at offset 0.
    typedef struct packed {
        logic [31:0] pcrc;
        logic [31:0] len;
        logic [31:0] count;
        logic [63:0] tstamp;
        logic [63:0] seq;
        logic [15:0] hsize;
        logic [15:0] version;
        logic [31:0] magic;
    } record_fields_t;

    typedef enum int {
        FLAW_NONE,
        FLAW_MAGIC,
        FLAW_VERSION,
        FLAW_SIZE,
        FLAW_COUNT,
        FLAW_LENGTH,
        FLAW_GARBLED
    } flaw_t;

    logic                            clk;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [rhc_pkg::CFG_INDEX_W-1:0] cfg_index = rhc_pkg::CFG_MAGIC_WORD;
    logic [rhc_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [7:0]                      s_axis_tdata = '0;   // [7:0] header_byte
    logic [0:0]                      s_axis_tuser = '0;   // [0] first
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    // From bit 0: status, sequence_res, start_time, sample_total, payload_length,
    // payload_crc, header_crc, zero padding.
    logic [rhc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    // Predictor configuration, mirrored from the write port.
    logic [31:0] exp_magic = rhc_pkg::MAGIC_WORD_RST;
    logic [15:0] exp_version = rhc_pkg::FORMAT_VERSION_RST;
    logic [31:0] exp_samples = rhc_pkg::SAMPLE_TARGET_RST;
    logic [31:0] exp_payload = rhc_pkg::PAYLOAD_TARGET_RST;
    logic [31:0] slot_bytes = rhc_pkg::SLOT_SIZE_RST;

    // Predictor parsing state.
    int          hdr_pos;
    logic [31:0] crc_acc;
    logic        id_good;
    logic [31:0] shift_win;
    logic [63:0] seq_acc;
    logic [63:0] time_acc;
    logic [31:0] cnt_acc;
    logic [31:0] len_acc;
    logic [31:0] pcrc_acc;
    logic [31:0] hcrc_acc;

    rhc_pkg::result_t awaited_verdicts[$];

    int   fail_count = 0;
    int   results_seen = 0;
    int   bytes_sent = 0;
    int   cycle_count = 0;
    int   tx_idle_pct = 0;
    int   rx_stall_pct = 0;
    logic rx_holding = 1'b0;
    event hold_off_go;

    record_header_checker_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Reflected CRC-32, one data bit per step, LSB first.
    function automatic logic [31:0] crc32_update(input logic [31:0] acc, input logic [7:0] d);
        logic [31:0] c;
        logic        fb;
        c = acc;
        for (int i = 0; i < 8; i++)
        begin
            fb = c[0] ^ d[i];
            c = c >> 1;
            if (fb)
                c = c ^ rhc_pkg::CRC_POLY_REFLECTED;
        end
        return c;
    endfunction

    function automatic logic [31:0] flip_mask(input int w);
        logic [31:0] m;
        m = $urandom() >> (32 - w);
        if (m == 0)
            m = 32'h1;
        return m;
    endfunction

    task automatic clear_parse();
        hdr_pos = 0;
        crc_acc = rhc_pkg::CRC_ALL_ONES;
        id_good = 1'b1;
        shift_win = '0;
        seq_acc = '0;
        time_acc = '0;
        cnt_acc = '0;
        len_acc = '0;
        pcrc_acc = '0;
        hcrc_acc = '0;
    endtask

    task automatic absorb_header_byte(input logic [7:0] b, input logic restart_flag);
        rhc_pkg::result_t r;
        if (restart_flag)
            clear_parse();
        // Once a header is complete, bytes are dropped until the next first byte.
        if (hdr_pos < HDR_LEN)
        begin
            shift_win = {b, shift_win[31:8]};
            // The stored CRC bytes enter the running CRC as zeros.
            if (hdr_pos >= 36 && hdr_pos < 40)
            begin
                crc_acc = crc32_update(crc_acc, 8'h00);
                hcrc_acc[8*(hdr_pos-36) +: 8] = b;
            end
            else
            begin
                crc_acc = crc32_update(crc_acc, b);
            end
            if (hdr_pos == 3 && shift_win != exp_magic)
                id_good = 1'b0;
            if (hdr_pos == 5 && shift_win[31:16] != exp_version)
                id_good = 1'b0;
            if (hdr_pos == 7 && shift_win[31:16] != 16'(HDR_LEN))
                id_good = 1'b0;
            if (hdr_pos >= 8 && hdr_pos < 16)
                seq_acc[8*(hdr_pos-8) +: 8] = b;
            if (hdr_pos >= 16 && hdr_pos < 24)
                time_acc[8*(hdr_pos-16) +: 8] = b;
            if (hdr_pos >= 24 && hdr_pos < 28)
                cnt_acc[8*(hdr_pos-24) +: 8] = b;
            if (hdr_pos >= 28 && hdr_pos < 32)
                len_acc[8*(hdr_pos-28) +: 8] = b;
            if (hdr_pos >= 32 && hdr_pos < 36)
                pcrc_acc[8*(hdr_pos-32) +: 8] = b;
            hdr_pos++;
            if (hdr_pos == HDR_LEN)
            begin
                if (!id_good)
                    r.status = rhc_pkg::STATUS_BAD_IDENTITY;
                else if ((crc_acc ^ rhc_pkg::CRC_ALL_ONES) != hcrc_acc)
                    r.status = rhc_pkg::STATUS_CRC_MISMATCH;
                else if (cnt_acc != exp_samples || len_acc != exp_payload ||
                         ({1'b0, len_acc} + 33'(HDR_LEN)) > {1'b0, slot_bytes})
                    r.status = rhc_pkg::STATUS_BAD_LENGTH;
                else
                    r.status = rhc_pkg::STATUS_VALID;
                r.sequence_res = seq_acc;
                r.start_time = time_acc;
                r.sample_total = cnt_acc;
                r.payload_length = len_acc;
                r.payload_crc = pcrc_acc;
                r.header_crc = hcrc_acc;
                awaited_verdicts.push_back(r);
            end
        end
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got)
        begin
            if (fail_count < 10)
                $display("Result mismatch on %s: expected %h, got %h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        rhc_pkg::result_t seen;
        rhc_pkg::result_t want;
        cycle_count <= cycle_count + 1;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (rhc_pkg::cfg_index_t'(cfg_index))
                    rhc_pkg::CFG_MAGIC_WORD:     exp_magic = cfg_data;
                    rhc_pkg::CFG_FORMAT_VERSION: exp_version = cfg_data[15:0];
                    rhc_pkg::CFG_SAMPLE_TARGET:  exp_samples = cfg_data;
                    rhc_pkg::CFG_PAYLOAD_TARGET: exp_payload = cfg_data;
                    rhc_pkg::CFG_SLOT_SIZE:      slot_bytes = cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                absorb_header_byte(s_axis_tdata, s_axis_tuser[0]);
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                seen = rhc_pkg::result_t'(m_axis_tdata[rhc_pkg::RESULT_W-1:0]);
                if (awaited_verdicts.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("Result transaction with no header pending: %h", m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    want = awaited_verdicts.pop_front();
                    compare_field("status", want.status, seen.status);
                    compare_field("sequence_res", want.sequence_res, seen.sequence_res);
                    compare_field("start_time", want.start_time, seen.start_time);
                    compare_field("sample_total", want.sample_total, seen.sample_total);
                    compare_field("payload_length", want.payload_length, seen.payload_length);
                    compare_field("payload_crc", want.payload_crc, seen.payload_crc);
                    compare_field("header_crc", want.header_crc, seen.header_crc);
                    compare_field("padding", 64'(m_axis_tdata >> rhc_pkg::RESULT_W), 64'd0);
                end
            end
        end
    end

    always @(negedge clk)
        m_axis_tready <= !rx_holding && ($urandom_range(99) >= rx_stall_pct);

    // Long receiver hold-off, counted here so the sender keeps offering meanwhile.
    initial
    begin
        forever
        begin
            @(hold_off_go);
            @(posedge clk);
            rx_holding = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            rx_holding = 1'b0;
        end
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b, input logic restart_flag);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tuser <= restart_flag;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // Sends the first nbytes of a header; the stored CRC is correct unless crc_ok is low.
    task automatic send_header(input record_fields_t f, input logic crc_ok,
                               input logic with_first, input int nbytes);
        logic [31:0]  c;
        logic [319:0] img;
        c = rhc_pkg::CRC_ALL_ONES;
        for (int i = 0; i < 36; i++)
            c = crc32_update(c, f[8*i +: 8]);
        for (int i = 0; i < 4; i++)
            c = crc32_update(c, 8'h00);
        c = c ^ rhc_pkg::CRC_ALL_ONES;
        if (!crc_ok)
            c = c ^ flip_mask(32);
        img = {c, f};
        for (int i = 0; i < nbytes; i++)
            send_byte(img[8*i +: 8], with_first && i == 0);
    endtask

    function automatic record_fields_t make_fields(input flaw_t flaw);
        record_fields_t f;
        f.magic = exp_magic;
        f.version = exp_version;
        f.hsize = 16'(HDR_LEN);
        f.seq = {$urandom(), $urandom()};
        f.tstamp = {$urandom(), $urandom()};
        f.count = exp_samples;
        f.len = exp_payload;
        f.pcrc = $urandom();
        case (flaw)
            FLAW_MAGIC:   f.magic = f.magic ^ flip_mask(32);
            FLAW_VERSION: f.version = f.version ^ 16'(flip_mask(16));
            FLAW_SIZE:    f.hsize = f.hsize ^ 16'(flip_mask(16));
            FLAW_COUNT:   f.count = f.count ^ flip_mask(32);
            FLAW_LENGTH:  f.len = f.len ^ flip_mask(32);
            FLAW_GARBLED:
            begin
                for (int i = 0; i < 9; i++)
                    f[32*i +: 32] = $urandom();
            end
            default: ;
        endcase
        return f;
    endfunction

    // Stops offering and waits until every pending result has been taken.
    task automatic settle_idle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (awaited_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input rhc_pkg::cfg_index_t idx, input logic [31:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
    endtask

    task automatic apply_config(input logic [31:0] magic, input logic [15:0] version,
                                input logic [31:0] samples, input logic [31:0] payload,
                                input logic [31:0] slot);
        settle_idle();
        write_reg(rhc_pkg::CFG_MAGIC_WORD, magic);
        write_reg(rhc_pkg::CFG_FORMAT_VERSION, 32'(version));
        write_reg(rhc_pkg::CFG_SAMPLE_TARGET, samples);
        write_reg(rhc_pkg::CFG_PAYLOAD_TARGET, payload);
        write_reg(rhc_pkg::CFG_SLOT_SIZE, slot);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Reset defaults, bytes before any first flag, trailing bytes and an abandoned header.
    task automatic test_reset_parsing();
        send_header(make_fields(FLAW_NONE), 1'b1, 1'b0, HDR_LEN);
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'($urandom()), 1'b0);
        send_header(make_fields(FLAW_NONE), 1'b1, 1'b1, 12);
        send_header(make_fields(FLAW_NONE), 1'b1, 1'b1, HDR_LEN);
    endtask

    task automatic test_identity_checks();
        record_fields_t f;
        apply_config($urandom(), 16'($urandom()), rhc_pkg::SAMPLE_TARGET_RST,
                     rhc_pkg::PAYLOAD_TARGET_RST, rhc_pkg::SLOT_SIZE_RST);
        send_header(make_fields(FLAW_MAGIC), 1'b1, 1'b1, HDR_LEN);
        send_header(make_fields(FLAW_VERSION), 1'b1, 1'b1, HDR_LEN);
        send_header(make_fields(FLAW_SIZE), 1'b1, 1'b1, HDR_LEN);
        // Identity takes precedence over the CRC, and the CRC over the counts.
        send_header(make_fields(FLAW_MAGIC), 1'b0, 1'b1, HDR_LEN);
        send_header(make_fields(FLAW_NONE), 1'b0, 1'b1, HDR_LEN);
        send_header(make_fields(FLAW_COUNT), 1'b0, 1'b1, HDR_LEN);
        f = make_fields(FLAW_NONE);
        f.seq = '1;
        f.tstamp = 64'h8000_0000_0000_0000;
        f.pcrc = '1;
        send_header(f, 1'b1, 1'b1, HDR_LEN);
        f.seq = '0;
        f.tstamp = 64'h7fff_ffff_ffff_ffff;
        f.pcrc = '0;
        send_header(f, 1'b1, 1'b1, HDR_LEN);
    endtask

    task automatic test_length_checks();
        logic [31:0] magic;
        logic [15:0] version;
        magic = $urandom();
        version = 16'($urandom());
        // Slot one byte short of header plus payload.
        apply_config(magic, version, 32'hffff_ffff, 32'd100, 32'd139);
        send_header(make_fields(FLAW_NONE), 1'b1, 1'b1, HDR_LEN);
        apply_config(magic, version, 32'hffff_ffff, 32'd100, 32'd140);
        send_header(make_fields(FLAW_NONE), 1'b1, 1'b1, HDR_LEN);
        send_header(make_fields(FLAW_COUNT), 1'b1, 1'b1, HDR_LEN);
        send_header(make_fields(FLAW_LENGTH), 1'b1, 1'b1, HDR_LEN);
        // The length sum must not wrap at 32 bits.
        apply_config(magic, version, 32'd1, 32'hffff_ffff, 32'hffff_ffff);
        send_header(make_fields(FLAW_NONE), 1'b1, 1'b1, HDR_LEN);
        // A slot smaller than the header itself can never hold a record.
        apply_config(magic, version, 32'd1, 32'd0, 32'd20);
        send_header(make_fields(FLAW_NONE), 1'b1, 1'b1, HDR_LEN);
        send_header(make_fields(FLAW_NONE), 1'b0, 1'b1, HDR_LEN);
    endtask

    task automatic run_random_traffic(input int min_bytes, input int min_results);
        int byte_mark;
        int result_mark;
        int sel;
        byte_mark = bytes_sent;
        result_mark = results_seen;
        while (bytes_sent - byte_mark < min_bytes || results_seen - result_mark < min_results)
        begin
            sel = $urandom_range(99);
            if (sel < 60)
            begin
                send_header(make_fields(($urandom_range(1) == 0) ? FLAW_NONE :
                                        flaw_t'($urandom_range(FLAW_LENGTH, FLAW_MAGIC))),
                            $urandom_range(4) != 0, 1'b1, HDR_LEN);
                if ($urandom_range(4) == 0)
                    repeat ($urandom_range(5, 1)) send_byte(8'($urandom()), 1'b0);
            end
            else if (sel < 70)
                send_header(make_fields(FLAW_GARBLED), $urandom_range(1) != 0, 1'b1, HDR_LEN);
            else if (sel < 80)
                send_header(make_fields(FLAW_NONE), 1'b1, 1'b1, $urandom_range(HDR_LEN - 1, 1));
            else if (sel < 90)
                repeat ($urandom_range(8, 1)) send_byte(8'($urandom()), $urandom_range(7) == 0);
            else if (sel < 97)
                send_header(make_fields(FLAW_NONE), 1'b1, 1'b0, HDR_LEN);
            else
                settle_idle();
        end
        // Finish on a whole header so the next register write finds the parser at rest.
        send_header(make_fields(FLAW_NONE), 1'b1, 1'b1, HDR_LEN);
    endtask

    task automatic test_idling_phases();
        logic [31:0] payload;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    payload = $urandom_range(4000);
                    apply_config($urandom(), 16'($urandom()), $urandom(), payload,
                                 payload + HDR_LEN + $urandom_range(200));
                    tx_idle_pct = 0;
                    rx_stall_pct = 0;
                end
                1:
                begin
                    apply_config(32'hffff_ffff, 16'hffff, 32'hffff_ffff,
                                 32'hffff_ffff - HDR_LEN, 32'hffff_ffff);
                    tx_idle_pct = 69;
                    rx_stall_pct = 0;
                end
                2:
                begin
                    apply_config(32'd0, 16'd0, 32'd1, 32'd0, 32'(HDR_LEN));
                    tx_idle_pct = 0;
                    rx_stall_pct = 69;
                end
                default:
                begin
                    apply_config($urandom(), rhc_pkg::FORMAT_VERSION_RST,
                                 rhc_pkg::SAMPLE_TARGET_RST, 32'd512, rhc_pkg::SLOT_SIZE_RST);
                    tx_idle_pct = 29;
                    rx_stall_pct = 29;
                end
            endcase
            run_random_traffic(60, 1);
        end
    endtask

    // The receiver holds off while whole headers keep coming, so the input stalls.
    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        -> hold_off_go;
        repeat (3) send_header(make_fields(FLAW_NONE), 1'b1, 1'b1, HDR_LEN);
        settle_idle();
    endtask

    initial
    begin
        clear_parse();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_parsing();
        test_identity_checks();
        test_length_checks();
        test_idling_phases();
        test_backpressure();
        settle_idle();
        if (fail_count == 0 && awaited_verdicts.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
